[rtl/mia_pkg.sv]
// Shared types, codes and field widths of the MIPS integer ALU and register file core.
`default_nettype none

package mia_pkg;

    // Field widths
    localparam int RegIdxW  = 5;
    localparam int WordW    = 32;
    localparam int ImmW     = 16;
    localparam int ModeW    = 5;
    localparam int StatusW  = 2;
    localparam int RegCount = 32;
    localparam int InDataW  = 48;
    localparam int OutDataW = 72;

    // Operation codes on the input beat
    localparam logic [ModeW-1:0] MODE_ADD   = 5'd0;
    localparam logic [ModeW-1:0] MODE_ADDU  = 5'd1;
    localparam logic [ModeW-1:0] MODE_SUB   = 5'd2;
    localparam logic [ModeW-1:0] MODE_SUBU  = 5'd3;
    localparam logic [ModeW-1:0] MODE_AND   = 5'd4;
    localparam logic [ModeW-1:0] MODE_OR    = 5'd5;
    localparam logic [ModeW-1:0] MODE_XOR   = 5'd6;
    localparam logic [ModeW-1:0] MODE_SLT   = 5'd7;
    localparam logic [ModeW-1:0] MODE_SLTU  = 5'd8;
    localparam logic [ModeW-1:0] MODE_SLL   = 5'd9;
    localparam logic [ModeW-1:0] MODE_SRL   = 5'd10;
    localparam logic [ModeW-1:0] MODE_SRA   = 5'd11;
    localparam logic [ModeW-1:0] MODE_SRLV  = 5'd12;
    localparam logic [ModeW-1:0] MODE_SRAV  = 5'd13;
    localparam logic [ModeW-1:0] MODE_ADDI  = 5'd14;
    localparam logic [ModeW-1:0] MODE_ADDIU = 5'd15;
    localparam logic [ModeW-1:0] MODE_ANDI  = 5'd16;
    localparam logic [ModeW-1:0] MODE_ORI   = 5'd17;
    localparam logic [ModeW-1:0] MODE_XORI  = 5'd18;
    localparam logic [ModeW-1:0] MODE_LUI   = 5'd19;

    // Internal ALU function codes
    localparam logic [3:0] ALU_ADD  = 4'd0;
    localparam logic [3:0] ALU_SUB  = 4'd1;
    localparam logic [3:0] ALU_AND  = 4'd2;
    localparam logic [3:0] ALU_OR   = 4'd3;
    localparam logic [3:0] ALU_XOR  = 4'd4;
    localparam logic [3:0] ALU_SLT  = 4'd5;
    localparam logic [3:0] ALU_SLTU = 4'd6;
    localparam logic [3:0] ALU_SLL  = 4'd7;
    localparam logic [3:0] ALU_SRL  = 4'd8;
    localparam logic [3:0] ALU_SRA  = 4'd9;
    localparam logic [3:0] ALU_PASS = 4'd10;

    // Result status codes
    localparam logic [StatusW-1:0] ST_OK      = 2'd0;
    localparam logic [StatusW-1:0] ST_OVF     = 2'd1;
    localparam logic [StatusW-1:0] ST_INVALID = 2'd2;

    localparam logic [WordW-1:0] PcStep = 32'd4;

    // Decoded instruction handed from front to back
    typedef struct packed {
        logic [3:0]         alu_op;
        logic [RegIdxW-1:0] rs;
        logic [RegIdxW-1:0] rt;
        logic [RegIdxW-1:0] dest;
        logic [RegIdxW-1:0] shamt;
        logic [WordW-1:0]   imm;
        logic               use_imm;
        logic               var_shift;
        logic               trap_ovf;
        logic               invalid;
    } t_uop;

endpackage

`default_nettype wire

[rtl/mips_integer_alu_regfile_core.sv]
// Top level of the MIPS integer ALU and register file core.
//
//  Channel   Dir  Ports                        Beat contents (low bit up)
//  s_axis    in   i_s_axis_t{valid,data}, o_   mode, rs, rt, rd, sa, immediate
//  m_axis    out  o_m_axis_t{valid,data}, i_   status, write_done, index, value, next_pc
//
// One instruction per cycle sustained while the output accepts. An accepted beat is
// queued, reads the register file into the execute stage, then executes into the result
// register, which then offers the result beat; a back-to-back dependency is served by
// a bypass from the instruction committing in the same cycle. Synchronous active-low
// reset clears the register file valid bits, PC and stage valids. An output stall fills
// the result register, execute stage and two-entry queue, then deasserts input ready.
`default_nettype none

module mips_integer_alu_regfile_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // mode[4:0], src_a_index[9:5], src_b_index[14:10], dest_index[19:15],
    // shift_amount[24:20], immediate[40:25], zero[47:41]
    input  wire logic [mia_pkg::InDataW-1:0]   i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // status[1:0], write_done[2], written_index[7:3], written_value[39:8],
    // next_pc[71:40]
    output logic [mia_pkg::OutDataW-1:0]       o_m_axis_tdata
);

    logic          q_valid;
    logic          q_pop;
    mia_pkg::t_uop q_uop;

    // Decode and buffer
    mia_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_uop   (q_uop),
        .i_q_pop   (q_pop)
    );

    // Execute and retire
    mia_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_uop   (q_uop),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

[rtl/mia_front.sv]
// Front end: decode and classify instructions, then buffer them in a two-entry queue.
`default_nettype none

module mia_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [mia_pkg::InDataW-1:0]  i_data,
    output logic                              o_q_valid,
    output mia_pkg::t_uop                     o_q_uop,
    input  wire logic                         i_q_pop
);

    logic [mia_pkg::ModeW-1:0]   mode;
    logic [mia_pkg::RegIdxW-1:0] rs;
    logic [mia_pkg::RegIdxW-1:0] rt;
    logic [mia_pkg::RegIdxW-1:0] rd;
    logic [mia_pkg::RegIdxW-1:0] sa;
    logic [mia_pkg::ImmW-1:0]    imm;
    logic [mia_pkg::WordW-1:0]   imm_sext;
    logic [mia_pkg::WordW-1:0]   imm_zext;
    mia_pkg::t_uop               dec;

    mia_pkg::t_uop r_q_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic          n_wptr;
    logic          n_rptr;
    logic [1:0]    n_count;
    logic          push;

    // Unpack the input beat
    assign mode     = i_data[4:0];
    assign rs       = i_data[9:5];
    assign rt       = i_data[14:10];
    assign rd       = i_data[19:15];
    assign sa       = i_data[24:20];
    assign imm      = i_data[40:25];
    assign imm_sext = {{(mia_pkg::WordW-mia_pkg::ImmW){imm[mia_pkg::ImmW-1]}}, imm};
    assign imm_zext = {{(mia_pkg::WordW-mia_pkg::ImmW){1'b0}}, imm};

    // Decode mode into ALU function, operand sources and reserved-field checks
    always_comb begin
        dec           = '0;
        dec.rs        = rs;
        dec.rt        = rt;
        dec.dest      = rd;
        dec.shamt     = sa;
        dec.imm       = imm_sext;
        dec.alu_op    = mia_pkg::ALU_PASS;
        case (mode)
            mia_pkg::MODE_ADD: begin
                dec.alu_op   = mia_pkg::ALU_ADD;
                dec.trap_ovf = 1'b1;
            end
            mia_pkg::MODE_ADDU:  dec.alu_op = mia_pkg::ALU_ADD;
            mia_pkg::MODE_SUB: begin
                dec.alu_op   = mia_pkg::ALU_SUB;
                dec.trap_ovf = 1'b1;
            end
            mia_pkg::MODE_SUBU:  dec.alu_op = mia_pkg::ALU_SUB;
            mia_pkg::MODE_AND:   dec.alu_op = mia_pkg::ALU_AND;
            mia_pkg::MODE_OR:    dec.alu_op = mia_pkg::ALU_OR;
            mia_pkg::MODE_XOR:   dec.alu_op = mia_pkg::ALU_XOR;
            mia_pkg::MODE_SLT: begin
                dec.alu_op  = mia_pkg::ALU_SLT;
                dec.invalid = (sa != '0);
            end
            mia_pkg::MODE_SLTU:  dec.alu_op = mia_pkg::ALU_SLTU;
            mia_pkg::MODE_SLL: begin
                dec.alu_op  = mia_pkg::ALU_SLL;
                dec.invalid = (rs != '0);
            end
            mia_pkg::MODE_SRL: begin
                dec.alu_op  = mia_pkg::ALU_SRL;
                dec.invalid = (rs != '0);
            end
            mia_pkg::MODE_SRA: begin
                dec.alu_op  = mia_pkg::ALU_SRA;
                dec.invalid = (rs != '0);
            end
            mia_pkg::MODE_SRLV: begin
                dec.alu_op    = mia_pkg::ALU_SRL;
                dec.var_shift = 1'b1;
                dec.invalid   = (sa != '0);
            end
            mia_pkg::MODE_SRAV: begin
                dec.alu_op    = mia_pkg::ALU_SRA;
                dec.var_shift = 1'b1;
                dec.invalid   = (sa != '0);
            end
            mia_pkg::MODE_ADDI: begin
                dec.alu_op   = mia_pkg::ALU_ADD;
                dec.use_imm  = 1'b1;
                dec.trap_ovf = 1'b1;
                dec.dest     = rt;
            end
            mia_pkg::MODE_ADDIU: begin
                dec.alu_op  = mia_pkg::ALU_ADD;
                dec.use_imm = 1'b1;
                dec.dest    = rt;
            end
            mia_pkg::MODE_ANDI: begin
                dec.alu_op  = mia_pkg::ALU_AND;
                dec.use_imm = 1'b1;
                dec.imm     = imm_zext;
                dec.dest    = rt;
            end
            mia_pkg::MODE_ORI: begin
                dec.alu_op  = mia_pkg::ALU_OR;
                dec.use_imm = 1'b1;
                dec.imm     = imm_zext;
                dec.dest    = rt;
            end
            mia_pkg::MODE_XORI: begin
                dec.alu_op  = mia_pkg::ALU_XOR;
                dec.use_imm = 1'b1;
                dec.imm     = imm_zext;
                dec.dest    = rt;
            end
            mia_pkg::MODE_LUI: begin
                dec.alu_op  = mia_pkg::ALU_PASS;
                dec.use_imm = 1'b1;
                dec.imm     = {imm, {mia_pkg::ImmW{1'b0}}};
                dec.dest    = rt;
                dec.invalid = (rs != '0);
            end
            default: dec.invalid = 1'b1;
        endcase
    end

    // Queue control
    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_uop   = r_q_mem[r_rptr];

    always_comb begin
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = i_q_pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the decoded beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_wptr] <= dec;
        end
    end

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wptr == r_rptr)
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

[rtl/mia_back.sv]
// Back end: register file, PC, operand bypass, ALU execute and result register.
`default_nettype none

module mia_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire mia_pkg::t_uop                 i_q_uop,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [mia_pkg::OutDataW-1:0]       o_data
);

    localparam int W = mia_pkg::WordW;

    // Register file storage and per-entry valid bits (invalid reads as zero)
    logic [W-1:0]                  r_rf [mia_pkg::RegCount];
    logic [mia_pkg::RegCount-1:0]  r_rf_valid;

    // Execute stage
    logic                 r_e_valid;
    mia_pkg::t_uop        r_e_uop;
    logic [W-1:0]         r_rd_a;
    logic [W-1:0]         r_rd_b;
    logic                 r_va;
    logic                 r_vb;
    logic                 r_byp_a;
    logic                 r_byp_b;
    logic [W-1:0]         r_wb_val;

    logic [W-1:0]         r_pc;

    // Result register
    logic                            r_o_valid;
    logic [mia_pkg::StatusW-1:0]     r_o_status;
    logic                            r_o_wdone;
    logic [mia_pkg::RegIdxW-1:0]     r_o_widx;
    logic [W-1:0]                    r_o_wval;
    logic [W-1:0]                    r_o_pc;

    logic                            e_adv;
    logic                            issue;
    logic                            commit;
    logic                            wr_en;
    logic [W-1:0]                    op_a;
    logic [W-1:0]                    op_b;
    logic [W-1:0]                    reg_b;
    logic [mia_pkg::RegIdxW-1:0]     sh;
    logic [W-1:0]                    sum;
    logic [W-1:0]                    diff;
    logic [W-1:0]                    res;
    logic                            ovf;
    logic [mia_pkg::StatusW-1:0]     status;
    logic [W-1:0]                    pc_next;

    // Stage handshakes
    assign e_adv   = !r_o_valid || i_ready;
    assign commit  = r_e_valid && e_adv;
    assign issue   = i_q_valid && (!r_e_valid || e_adv);
    assign o_q_pop = issue;

    // Operand select with bypass from the instruction committing ahead
    assign op_a  = r_byp_a ? r_wb_val : (r_va ? r_rd_a : '0);
    assign reg_b = r_byp_b ? r_wb_val : (r_vb ? r_rd_b : '0);
    assign op_b  = r_e_uop.use_imm ? r_e_uop.imm : reg_b;
    assign sh    = r_e_uop.var_shift ? op_a[mia_pkg::RegIdxW-1:0] : r_e_uop.shamt;
    assign sum   = op_a + op_b;
    assign diff  = op_a - op_b;

    // ALU
    always_comb begin
        res = '0;
        ovf = 1'b0;
        case (r_e_uop.alu_op)
            mia_pkg::ALU_ADD: begin
                res = sum;
                ovf = r_e_uop.trap_ovf && ((op_a[W-1] ~^ op_b[W-1]) &&
                      (sum[W-1] != op_a[W-1]));
            end
            mia_pkg::ALU_SUB: begin
                res = diff;
                ovf = r_e_uop.trap_ovf && ((op_a[W-1] != op_b[W-1]) &&
                      (diff[W-1] != op_a[W-1]));
            end
            mia_pkg::ALU_AND:  res = op_a & op_b;
            mia_pkg::ALU_OR:   res = op_a | op_b;
            mia_pkg::ALU_XOR:  res = op_a ^ op_b;
            mia_pkg::ALU_SLT:  res = {{(W-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
            mia_pkg::ALU_SLTU: res = {{(W-1){1'b0}}, (op_a < op_b)};
            mia_pkg::ALU_SLL:  res = op_b << sh;
            mia_pkg::ALU_SRL:  res = op_b >> sh;
            mia_pkg::ALU_SRA:  res = W'($signed(op_b) >>> sh);
            mia_pkg::ALU_PASS: res = op_b;
            default:           res = '0;
        endcase
    end

    // Status and architectural update
    always_comb begin
        if (r_e_uop.invalid) begin
            status = mia_pkg::ST_INVALID;
        end else if (ovf) begin
            status = mia_pkg::ST_OVF;
        end else begin
            status = mia_pkg::ST_OK;
        end
    end

    assign wr_en   = (status == mia_pkg::ST_OK) && (r_e_uop.dest != '0);
    assign pc_next = (status == mia_pkg::ST_OK) ? (r_pc + mia_pkg::PcStep) : r_pc;

    // Register file write and read
    always_ff @(posedge i_clk) begin
        if (commit && wr_en) begin
            r_rf[r_e_uop.dest] <= res;
        end
        if (issue) begin
            r_rd_a <= r_rf[i_q_uop.rs];
            r_rd_b <= r_rf[i_q_uop.rt];
        end
    end

    // Control state: valids, PC, stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
            r_pc       <= '0;
            r_e_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_byp_a    <= 1'b0;
            r_byp_b    <= 1'b0;
        end else begin
            if (commit) begin
                r_pc <= pc_next;
                if (wr_en) begin
                    r_rf_valid[r_e_uop.dest] <= 1'b1;
                end
            end
            if (issue) begin
                r_e_valid <= 1'b1;
                r_byp_a   <= commit && wr_en && (r_e_uop.dest == i_q_uop.rs);
                r_byp_b   <= commit && wr_en && (r_e_uop.dest == i_q_uop.rt);
            end else if (commit) begin
                r_e_valid <= 1'b0;
                r_byp_a   <= 1'b0;
                r_byp_b   <= 1'b0;
            end
            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload of execute and result registers
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_e_uop <= i_q_uop;
            r_va    <= r_rf_valid[i_q_uop.rs];
            r_vb    <= r_rf_valid[i_q_uop.rt];
        end
        if (commit) begin
            if (wr_en) begin
                r_wb_val <= res;
            end
            r_o_status <= status;
            r_o_wdone  <= wr_en;
            r_o_widx   <= wr_en ? r_e_uop.dest : '0;
            r_o_wval   <= wr_en ? res : '0;
            r_o_pc     <= pc_next;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = {r_o_pc, r_o_wval, r_o_widx, r_o_wdone, r_o_status};

`ifndef SYNTH
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != mia_pkg::ST_OK) |-> !r_o_wdone)
        else $error("error result reports a register write");
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && status == mia_pkg::ST_OK) |=> r_pc == $past(r_pc) + mia_pkg::PcStep)
        else $error("PC did not advance after successful commit");
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_pc))
        else $error("PC changed without a commit");
    a_zero_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rf_valid[0])
        else $error("register zero marked written");
    a_byp_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byp_a || r_byp_b) |-> r_e_valid)
        else $error("bypass flag set with empty execute stage");
`endif

endmodule

`default_nettype wire
